// File: src/sabeb_pkg.sv
// shared types and constants of the segment addback event builder
package sabeb_pkg;

   localparam int unsigned EVENT_W  = 32;
   localparam int unsigned CRYSTAL_W = 2;
   localparam int unsigned DET_W    = 5;
   localparam int unsigned ENERGY_W = 20;
   localparam int unsigned SUM_W    = 24;
   localparam int unsigned SEGOUT_W = 4;
   localparam int unsigned HITS_W   = 5;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

   // crystal codes
   localparam logic [CRYSTAL_W-1:0] CRYSTAL_SEG   = 2'd0;
   localparam logic [CRYSTAL_W-1:0] CRYSTAL_VETO1 = 2'd1;
   localparam logic [CRYSTAL_W-1:0] CRYSTAL_VETO2 = 2'd2;

   // register indexes
   localparam logic [1:0] REG_VETO_THR  = 2'd0;
   localparam logic [1:0] REG_HIT_THR   = 2'd1;
   localparam logic [1:0] REG_NEIGH_THR = 2'd2;
   localparam logic [1:0] REG_MATCH_TOL = 2'd3;

   // reset values of the registers
   localparam logic [ENERGY_W-1:0] VETO_THR_RST  = 20'd6400;
   localparam logic [ENERGY_W-1:0] HIT_THR_RST   = 20'd6;
   localparam logic [ENERGY_W-1:0] NEIGH_THR_RST = 20'd1920;
   localparam logic [ENERGY_W-1:0] MATCH_TOL_RST = 20'd320;

   typedef struct packed {
      logic [EVENT_W-1:0]   event_number;
      logic [CRYSTAL_W-1:0] crystal;
      logic [DET_W-1:0]     detector_index;
      logic [ENERGY_W-1:0]  deposit_energy;
      logic                 last_row;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]    addback_energy;
      logic [SEGOUT_W-1:0] segment;
      logic                vetoed;
      logic                accepted;
      logic [HITS_W-1:0]   hit_count;
      logic                last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] veto_threshold;
      logic [ENERGY_W-1:0] hit_threshold;
      logic [ENERGY_W-1:0] neighbour_threshold;
      logic [ENERGY_W-1:0] match_tolerance;
   } cfg_type;

   // classified row handed from front to back
   typedef struct packed {
      logic                close_first;
      logic                last_row;
      logic                veto_one;
      logic                veto_two;
      logic                hit;
      logic [DET_W-1:0]    hit_index;
      logic [ENERGY_W-1:0] energy;
   } cmd_type;

   // queue status seen by the front and back ends
   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

endpackage

// File: src/sabeb_front.sv
// front end: accepts hit rows, tracks the event number and classifies each row
module sabeb_front #(
   parameter int SEGMENTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sabeb_pkg::req_type req_data,
   input  sabeb_pkg::cfg_type cfg,
   input  sabeb_pkg::qstat_type qstat,
   output logic              push,
   output sabeb_pkg::cmd_type push_cmd
);
   import sabeb_pkg::*;

   logic [EVENT_W-1:0] current_event_ff;
   logic [EVENT_W-1:0] current_event_in;
   logic [DET_W+1:0]   det_ext;
   logic               det_ok;

   assign req_ready = !qstat.full;
   assign push      = req_valid && !qstat.full;

   // segment range check
   assign det_ext = {2'b00, req_data.detector_index};
   assign det_ok  = (req_data.detector_index != '0) && (det_ext <= (DET_W+2)'(SEGMENTS));

   // row classification
   always_comb begin
      push_cmd.close_first = (req_data.event_number != current_event_ff);
      push_cmd.last_row    = req_data.last_row;
      push_cmd.veto_one    = (req_data.crystal == CRYSTAL_VETO1) &&
                             (req_data.deposit_energy > cfg.veto_threshold);
      push_cmd.veto_two    = (req_data.crystal == CRYSTAL_VETO2) &&
                             (req_data.deposit_energy > cfg.veto_threshold);
      push_cmd.hit         = (req_data.crystal == CRYSTAL_SEG) &&
                             (req_data.deposit_energy > cfg.hit_threshold) && det_ok;
      push_cmd.hit_index   = req_data.detector_index - DET_W'(1);
      push_cmd.energy      = req_data.deposit_energy;
   end

   // event number of the open event
   assign current_event_in = push ? req_data.event_number : current_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_event_ff <= '0;
      end else begin
         current_event_ff <= current_event_in;
      end
   end

endmodule

// File: src/sabeb_queue.sv
// short command queue between front and back
module sabeb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sabeb_pkg::cmd_type push_cmd,
   input  logic               pop,
   output sabeb_pkg::cmd_type pop_cmd,
   output sabeb_pkg::qstat_type qstat
);
   import sabeb_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign qstat.not_empty = (count_ff != '0);
   assign qstat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push = push && !qstat.full;
   assign do_pop  = pop && qstat.not_empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/sabeb_back.sv
// back end: event accumulation, close-out scan and result register
module sabeb_back #(
   parameter int SEGMENTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sabeb_pkg::cfg_type   cfg,
   input  sabeb_pkg::qstat_type qstat,
   input  sabeb_pkg::cmd_type   pop_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sabeb_pkg::rsp_type   rsp_data
);
   import sabeb_pkg::*;

   localparam int unsigned SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int unsigned RUN_W = ENERGY_W + SEG_W;
   localparam int unsigned CMP_W = (RUN_W > SUM_W) ? RUN_W : SUM_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_CLOSE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic                 phase_last_ff;
   logic [ENERGY_W-1:0]  energy_ff [SEGMENTS];
   logic [SEGMENTS-1:0]  valid_ff;
   logic                 veto_one_ff, veto_two_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [HITS_W-1:0]    hits_ff;
   logic [SEG_W-1:0]     chosen_ff;
   logic [SEG_W-1:0]     idx_ff;
   logic [RUN_W-1:0]     run_ff;
   logic                 run_on_ff;
   logic [ENERGY_W-1:0]  best_ff;
   logic [SEG_W-1:0]     best_idx_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [SEG_W-1:0]     row_sel;
   logic [SUM_W:0]       sum_add;
   logic [ENERGY_W-1:0]  scan_e;
   logic                 scan_in_run;
   logic                 multi_hit;
   logic [CMP_W-1:0]     run_ext, sum_ext, diff;
   logic [SUM_W-1:0]     ab_final;
   logic [SEG_W-1:0]     seg_final;
   logic                 slot_free;

   assign pop       = (state_ff == S_IDLE) && qstat.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // row accumulation terms
   assign row_sel = SEG_W'(cmd_ff.hit_index);
   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(cmd_ff.energy);

   // one segment per scan cycle
   assign scan_e      = valid_ff[idx_ff] ? energy_ff[idx_ff] : '0;
   assign scan_in_run = (scan_e > cfg.neighbour_threshold);

   // run check against the addback sum
   assign multi_hit = (hits_ff > HITS_W'(1));
   assign run_ext   = CMP_W'(run_ff);
   assign sum_ext   = CMP_W'(sum_ff);
   assign diff      = (run_ext >= sum_ext) ? run_ext - sum_ext : sum_ext - run_ext;
   assign ab_final  = (multi_hit && (diff > CMP_W'(cfg.match_tolerance))) ? '0 : sum_ff;
   assign seg_final = run_on_ff ? best_idx_ff : chosen_ff;

   // sequencer, event state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_last_ff <= 1'b0;
         valid_ff      <= '0;
         veto_one_ff   <= 1'b0;
         veto_two_ff   <= 1'b0;
         sum_ff        <= '0;
         hits_ff       <= '0;
         chosen_ff     <= '0;
         run_on_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // result beat taken and no new result loaded
         if (rsp_ready && !((state_ff == S_EMIT) && slot_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (qstat.not_empty) begin
                  cmd_ff <= pop_cmd;
                  if (pop_cmd.close_first) begin
                     phase_last_ff <= 1'b0;
                     state_ff      <= S_CLOSE;
                  end else begin
                     state_ff <= S_ROW;
                  end
               end
            end
            S_ROW: begin
               if (cmd_ff.veto_one) begin
                  veto_one_ff <= 1'b1;
               end
               if (cmd_ff.veto_two) begin
                  veto_two_ff <= 1'b1;
               end
               if (cmd_ff.hit) begin
                  sum_ff              <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                  energy_ff[row_sel]  <= cmd_ff.energy;
                  valid_ff[row_sel]   <= 1'b1;
                  chosen_ff           <= row_sel;
                  if (hits_ff != HITS_MAX) begin
                     hits_ff <= hits_ff + HITS_W'(1);
                  end
               end
               if (cmd_ff.last_row) begin
                  phase_last_ff <= 1'b1;
                  state_ff      <= S_CLOSE;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_CLOSE: begin
               idx_ff      <= '0;
               run_ff      <= '0;
               run_on_ff   <= 1'b0;
               best_ff     <= '0;
               best_idx_ff <= '0;
               state_ff    <= multi_hit ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
               if (scan_in_run) begin
                  run_ff    <= run_ff + RUN_W'(scan_e);
                  run_on_ff <= 1'b1;
                  if (scan_e > best_ff) begin
                     best_ff     <= scan_e;
                     best_idx_ff <= idx_ff;
                  end
               end
               if ((!scan_in_run && run_on_ff) || (idx_ff == SEG_W'(SEGMENTS - 1))) begin
                  state_ff <= S_EMIT;
               end
               idx_ff <= idx_ff + SEG_W'(1);
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_ff.addback_energy <= ab_final;
                  rsp_ff.segment        <= SEGOUT_W'(seg_final);
                  rsp_ff.vetoed         <= veto_one_ff || veto_two_ff;
                  rsp_ff.accepted       <= (ab_final > SUM_W'(cfg.hit_threshold));
                  rsp_ff.hit_count      <= hits_ff;
                  rsp_ff.last_of_run    <= phase_last_ff || !cmd_ff.last_row;
                  rsp_valid_ff          <= 1'b1;
                  chosen_ff             <= seg_final;
                  // clear the event
                  valid_ff    <= '0;
                  veto_one_ff <= 1'b0;
                  veto_two_ff <= 1'b0;
                  sum_ff      <= '0;
                  hits_ff     <= '0;
                  run_on_ff   <= 1'b0;
                  state_ff    <= phase_last_ff ? S_IDLE : S_ROW;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: src/segment_addback_event_builder_top.sv
// top level: register port, front end, command queue and back end
// a row's beat updates the event state after acceptance via the back end pop and apply states
// a close passes the close state, then scans the segments up to the run end
// (scan only when more than one hit), the result is in the output register after it
// the back end takes one row at a time, popping the next only in idle; closes add the scan
// reset: synchronous, clears event state, queue and result register, loads register defaults
module segment_addback_event_builder_top #(
   parameter int SEGMENTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sabeb_pkg::req_type         req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sabeb_pkg::rsp_type         rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sabeb_pkg::ADDR_W-1:0] paddr,
   input  logic [sabeb_pkg::DATA_W-1:0] pwdata,
   output logic [sabeb_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import sabeb_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   qstat_type qstat;
   cmd_type   push_cmd;
   cmd_type   pop_cmd;
   logic      push;
   logic      pop;
   logic      wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_VETO_THR:  cfg_in.veto_threshold      = pwdata[ENERGY_W-1:0];
            REG_HIT_THR:   cfg_in.hit_threshold       = pwdata[ENERGY_W-1:0];
            REG_NEIGH_THR: cfg_in.neighbour_threshold = pwdata[ENERGY_W-1:0];
            REG_MATCH_TOL: cfg_in.match_tolerance     = pwdata[ENERGY_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.veto_threshold      <= VETO_THR_RST;
         cfg_ff.hit_threshold       <= HIT_THR_RST;
         cfg_ff.neighbour_threshold <= NEIGH_THR_RST;
         cfg_ff.match_tolerance     <= MATCH_TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      unique case (reg_sel)
         REG_VETO_THR:  prdata = DATA_W'(cfg_ff.veto_threshold);
         REG_HIT_THR:   prdata = DATA_W'(cfg_ff.hit_threshold);
         REG_NEIGH_THR: prdata = DATA_W'(cfg_ff.neighbour_threshold);
         REG_MATCH_TOL: prdata = DATA_W'(cfg_ff.match_tolerance);
         default:       prdata = '0;
      endcase
   end

   sabeb_front #(
      .SEGMENTS (SEGMENTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   sabeb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   sabeb_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/sv/segment_addback_event_builder_top_test.sv
// testbench of the segment addback event builder: directed and random hit rows, scoreboard check
module segment_addback_event_builder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sabeb_pkg::*;

   localparam int SEG_COUNT = 16;
   localparam int unsigned E_MAX = (1 << ENERGY_W) - 1;
   localparam logic [CRYSTAL_W-1:0] CRYSTAL_NONE = 2'd3;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_LIMIT = 40;

   // event builder predictor and expected event store
   class addback_scoreboard;
      logic [ENERGY_W-1:0] veto_thr, hit_thr, neigh_thr, match_tol;
      logic [ENERGY_W-1:0] seg_energy [SEG_COUNT];
      logic [EVENT_W-1:0]  open_event;
      bit                  veto_one_seen, veto_two_seen;
      int unsigned         energy_sum;
      int unsigned         hit_total;
      logic [SEGOUT_W-1:0] picked_segment;
      rsp_type             expected_events[$];
      int errors, printed, rows_noted, events_checked, n_accepted, n_vetoed, n_zeroed;

      function new();
         veto_thr = VETO_THR_RST;
         hit_thr = HIT_THR_RST;
         neigh_thr = NEIGH_THR_RST;
         match_tol = MATCH_TOL_RST;
         open_event = '0;
         picked_segment = '0;
         clear_event();
      endfunction

      function void set_reg(logic [1:0] idx, logic [ENERGY_W-1:0] v);
         case (idx)
            REG_VETO_THR: veto_thr = v;
            REG_HIT_THR: hit_thr = v;
            REG_NEIGH_THR: neigh_thr = v;
            REG_MATCH_TOL: match_tol = v;
            default: ;
         endcase
      endfunction

      function void clear_event();
         foreach (seg_energy[i]) seg_energy[i] = '0;
         veto_one_seen = 0;
         veto_two_seen = 0;
         energy_sum = 0;
         hit_total = 0;
      endfunction

      // addback rule on close: first contiguous run above the neighbour threshold
      function rsp_type close_event();
         rsp_type r;
         longint unsigned run, diff, ab;
         logic [ENERGY_W-1:0] best;
         ab = energy_sum;
         if (hit_total > 1) begin
            run = 0;
            best = '0;
            for (int i = 0; i < SEG_COUNT; i++) begin
               if (seg_energy[i] > neigh_thr) begin
                  run += seg_energy[i];
                  if (seg_energy[i] > best) begin
                     best = seg_energy[i];
                     picked_segment = SEGOUT_W'(i);
                  end
               end else if (run > 0) begin
                  break;
               end
            end
            diff = (run > ab) ? run - ab : ab - run;
            if (diff > match_tol) begin
               ab = 0;
               n_zeroed++;
            end
         end
         r.addback_energy = SUM_W'(ab);
         r.segment = picked_segment;
         r.vetoed = veto_one_seen || veto_two_seen;
         r.accepted = ab > hit_thr;
         r.hit_count = HITS_W'(hit_total);
         r.last_of_run = 1'b0;
         clear_event();
         return r;
      endfunction

      // one accepted row beat: update state, queue the events it closes
      function void note_row(req_type row);
         rsp_type outs [2];
         int n;
         n = 0;
         rows_noted++;
         if (row.event_number != open_event) begin
            outs[n] = close_event();
            n++;
            open_event = row.event_number;
         end
         if (row.crystal == CRYSTAL_VETO1 && row.deposit_energy > veto_thr) veto_one_seen = 1;
         if (row.crystal == CRYSTAL_VETO2 && row.deposit_energy > veto_thr) veto_two_seen = 1;
         if (row.crystal == CRYSTAL_SEG && row.deposit_energy > hit_thr &&
             row.detector_index > 0 && row.detector_index <= SEG_COUNT) begin
            energy_sum += row.deposit_energy;
            if (energy_sum > SUM_MAX) energy_sum = SUM_MAX;
            seg_energy[row.detector_index - 1] = row.deposit_energy;
            if (hit_total < HITS_MAX) hit_total++;
            picked_segment = SEGOUT_W'(row.detector_index - 1);
         end
         if (row.last_row) begin
            outs[n] = close_event();
            n++;
         end
         if (n > 0) outs[n-1].last_of_run = 1'b1;
         for (int i = 0; i < n; i++) expected_events.push_back(outs[i]);
      endfunction

      function void check_field(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            errors++;
            if (printed < PRINT_LIMIT) begin
               printed++;
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            end
         end
      endfunction

      // one result beat against the oldest expected event
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual addback %0d segment %0d",
                     $time, got.addback_energy, got.segment);
            return;
         end
         want = expected_events.pop_front();
         events_checked++;
         if (want.accepted) n_accepted++;
         if (want.vetoed) n_vetoed++;
         check_field("addback_energy", want.addback_energy, got.addback_energy);
         check_field("segment", want.segment, got.segment);
         check_field("vetoed", want.vetoed, got.vetoed);
         check_field("accepted", want.accepted, got.accepted);
         check_field("hit_count", want.hit_count, got.hit_count);
         check_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   addback_scoreboard book = new();
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_cnt = 0;
   int quiet_cycles = 0;
   logic [EVENT_W-1:0] last_ev = '0;
   req_type batch[$];

   segment_addback_event_builder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check each beat, random stall bursts, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) book.check_result(rsp_data);
         if (hold_request) begin
            hold_cnt = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (stalls_on && $urandom_range(9, 0) == 0) begin
            hold_cnt = $urandom_range(19, 1) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d events outstanding",
                     $time, quiet_cycles, book.pending());
            $display("segment_addback_event_builder_top test failed");
            $finish;
         end
      end
   end

   function automatic req_type make_row(logic [EVENT_W-1:0] ev, logic [CRYSTAL_W-1:0] cry,
                                        int unsigned det, int unsigned e, bit last);
      req_type r;
      r.event_number = ev;
      r.crystal = cry;
      r.detector_index = DET_W'(det);
      r.deposit_energy = ENERGY_W'(e);
      r.last_row = last;
      return r;
   endfunction

   function automatic int unsigned near_value(int unsigned center, int unsigned spread);
      longint v;
      v = longint'(center) + longint'($urandom_range(2 * spread, 0)) - longint'(spread);
      if (v < 0) v = 0;
      if (v > E_MAX) v = E_MAX;
      return int'(v);
   endfunction

   function automatic int unsigned pick_energy();
      case ($urandom_range(5, 0))
         0: return $urandom_range(E_MAX, 0);
         1: return near_value(book.neigh_thr, 3);
         2: return near_value(book.hit_thr, 2);
         3: return near_value(book.veto_thr, 2);
         4: return $urandom_range(3000, 0);
         default: return $urandom_range(E_MAX, E_MAX - 1000);
      endcase
   endfunction

   function automatic logic [CRYSTAL_W-1:0] pick_crystal();
      int unsigned v;
      v = $urandom_range(19, 0);
      if (v < 14) return CRYSTAL_SEG;
      if (v < 17) return CRYSTAL_VETO1;
      if (v < 19) return CRYSTAL_VETO2;
      return CRYSTAL_NONE;
   endfunction

   // build one event into the batch: a clean contiguous run, a long burst or loose rows
   function automatic void fill_event();
      logic [EVENT_W-1:0] ev;
      int unsigned kind, n, k, s, base, span;
      kind = $urandom_range(19, 0);
      case ($urandom_range(9, 0))
         0: ev = last_ev;
         1: ev = $urandom;
         2: ev = $urandom_range(1, 0) ? '1 : '0;
         default: ev = last_ev + 1;
      endcase
      base = book.neigh_thr + 1;
      batch.delete();
      if (kind == 0) begin
         // long burst drives the sum and hit count into saturation
         n = $urandom_range(40, 32);
         for (int i = 0; i < n; i++)
            batch.push_back(make_row(ev, CRYSTAL_SEG, $urandom_range(SEG_COUNT, 1),
                                     $urandom_range(E_MAX, 'hC0000), 0));
      end else if (kind <= 9 && base <= E_MAX) begin
         if ($urandom_range(3, 0) == 0)
            batch.push_back(make_row(ev, $urandom_range(1, 0) ? CRYSTAL_VETO1 : CRYSTAL_VETO2,
                                     0, pick_energy(), 0));
         k = $urandom_range(5, 2);
         s = $urandom_range(SEG_COUNT + 1 - k, 1);
         span = (E_MAX - base < 40000) ? E_MAX - base : 40000;
         for (int i = 0; i < k; i++)
            batch.push_back(make_row(ev, CRYSTAL_SEG, s + i, base + $urandom_range(span, 0), 0));
         if ($urandom_range(2, 0) == 0)
            batch.push_back(make_row(ev, CRYSTAL_SEG, $urandom_range(SEG_COUNT, 1),
                                     $urandom_range(300, 0), 0));
      end else begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++)
            batch.push_back(make_row(ev, pick_crystal(),
                                     ($urandom_range(4, 0) == 0) ? $urandom_range(31, 0)
                                                                 : $urandom_range(SEG_COUNT, 1),
                                     pick_energy(), 0));
      end
      // noise: stray closes and stray event numbers
      foreach (batch[i]) begin
         if ($urandom_range(39, 0) == 0) batch[i].last_row = 1'b1;
         if ($urandom_range(49, 0) == 0) batch[i].event_number = $urandom;
      end
      if ($urandom_range(2, 0) == 0) batch[batch.size()-1].last_row = 1'b1;
      last_ev = ev;
   endfunction

   // one row beat, with an optional idle burst before it
   task automatic send_row(req_type row);
      if (gaps_on && $urandom_range(5, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= row;
      do @(posedge clock); while (!req_ready);
      book.note_row(row);
   endtask

   task automatic random_rows(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         fill_event();
         foreach (batch[i]) send_row(batch[i]);
         sent += batch.size();
      end
   endtask

   // wait for all expected events, then for the close-out scan to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= DATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      book.set_reg(idx, ENERGY_W'(v));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int unsigned veto, int unsigned hit, int unsigned neigh,
                            int unsigned tol);
      drain();
      write_reg(REG_VETO_THR, veto);
      write_reg(REG_HIT_THR, hit);
      write_reg(REG_NEIGH_THR, neigh);
      write_reg(REG_MATCH_TOL, tol);
   endtask

   // close the open event so no row straddles a register change
   task automatic close_open_event();
      send_row(make_row(last_ev, CRYSTAL_NONE, 0, 0, 1));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed rows on the reset register values
      send_row(make_row(5, CRYSTAL_SEG, 1, 3000, 0));     // closes the empty first event
      send_row(make_row(5, CRYSTAL_SEG, 2, 2500, 0));
      send_row(make_row(5, CRYSTAL_SEG, 3, 100, 0));      // ends the run
      send_row(make_row(5, CRYSTAL_SEG, 5, 4000, 0));     // outside the run, sum rejected
      send_row(make_row(6, CRYSTAL_SEG, 16, E_MAX, 1));   // change and last row together
      send_row(make_row(6, CRYSTAL_VETO1, 0, 7000, 0));
      send_row(make_row(6, CRYSTAL_VETO2, 31, E_MAX, 0));
      send_row(make_row(6, CRYSTAL_NONE, 16, E_MAX, 0));
      send_row(make_row(6, CRYSTAL_SEG, 0, 5000, 0));     // guard ring
      send_row(make_row(6, CRYSTAL_SEG, 17, 5000, 0));
      send_row(make_row(6, CRYSTAL_SEG, 31, 5000, 0));
      send_row(make_row(6, CRYSTAL_SEG, 4, 6, 0));        // at the hit threshold
      send_row(make_row(7, CRYSTAL_SEG, 4, 3000, 0));
      send_row(make_row(7, CRYSTAL_SEG, 4, 2500, 1));     // repeated segment
      send_row(make_row(8, CRYSTAL_SEG, 7, 2000, 0));
      send_row(make_row(8, CRYSTAL_SEG, 8, 2100, 0));
      send_row(make_row(8, CRYSTAL_SEG, 9, 2200, 1));     // run matches the sum
      send_row(make_row(9, CRYSTAL_SEG, 3, 5000, 0));
      send_row(make_row(9, CRYSTAL_SEG, 4, 5000, 1));     // tie keeps the first
      send_row(make_row(10, CRYSTAL_SEG, 1, 100, 0));
      send_row(make_row(10, CRYSTAL_SEG, 2, 200, 1));     // no segment in a run
      send_row(make_row(11, CRYSTAL_SEG, 2, 7, 0));
      send_row(make_row('1, CRYSTAL_SEG, 1, 0, 0));
      send_row(make_row('0, CRYSTAL_VETO1, 0, 6401, 1));
      last_ev = '0;

      // moderate thresholds, with a long receiver hold mid phase
      configure(3000, 20, 1000, 500);
      random_rows(150);
      hold_request = 1'b1;
      gaps_on = 1'b0;
      random_rows(100);
      gaps_on = 1'b1;
      random_rows(350);
      close_open_event();

      // all thresholds at zero
      configure(0, 0, 0, 0);
      random_rows(300);
      close_open_event();

      // all thresholds at full scale
      configure(E_MAX, E_MAX, E_MAX, E_MAX);
      random_rows(150);
      close_open_event();

      // random thresholds, widest tolerance
      configure($urandom_range(E_MAX, 0), $urandom_range(500, 0), $urandom_range(100000, 0),
                E_MAX);
      random_rows(400);
      close_open_event();

      // last part without idling on either side
      configure(6400, 6, 1920, 0);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      random_rows(450);
      close_open_event();
      drain();

      $display("summary: %0d rows over the reset values and five register settings, %0d events",
               book.rows_noted, book.events_checked);
      $display("summary: %0d accepted, %0d vetoed, %0d rejected by the run check",
               book.n_accepted, book.n_vetoed, book.n_zeroed);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("segment_addback_event_builder_top test passed");
      end else begin
         $display("segment_addback_event_builder_top test failed");
      end
      $finish;
   end

endmodule
